FILE: sv/lab_pkg.sv
// Shared types, widths and codes for the look-at basis builder.
`default_nettype none

package lab_pkg;

  localparam int IN_W      = 32;
  localparam int OUT_W     = 16;
  localparam int OUT_FRAC  = 14;
  localparam int VEC_W     = IN_W + 2;
  localparam int MAG33_W   = IN_W + 1;
  localparam int P_W       = $clog2(MAG33_W);
  localparam int MAG_W     = 30;
  localparam int NORM_POS  = MAG_W - 1;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int SUM_W     = SQ_W + 2;
  localparam int ROOT_W    = SUM_W / 2;
  localparam int SQ_STEPS  = ROOT_W;
  localparam int REM_W     = ROOT_W + 2;
  localparam int Q_W       = OUT_FRAC + 1;
  localparam int DIV_STEPS = Q_W;
  localparam int NUM_W     = MAG_W + OUT_FRAC + 1;
  localparam int ONE_OUT   = 1 << OUT_FRAC;
  localparam int HALF_OUT  = 1 << (OUT_FRAC - 1);
  localparam int PROD_W    = 2 * OUT_W;

  localparam logic [1:0] MODE_X = 2'd0;
  localparam logic [1:0] MODE_Z = 2'd1;
  localparam logic [1:0] MODE_Y = 2'd2;

  typedef logic signed [OUT_W-1:0] out_t;
  typedef logic [3:0][VEC_W-1:0] vec4_t;
  typedef logic [3:0][OUT_W-1:0] res4_t;

  typedef struct packed {
    logic [1:0] mode;
    out_t       lx;
    out_t       ly;
    out_t       lz;
    out_t       lw;
  } side_t;

  typedef struct packed {
    side_t                  side;
    logic                   zero;
    logic [3:0]             neg;
    logic [3:0][MAG_W-1:0]  mag;
  } norm_pl_t;

  typedef struct packed {
    out_t right_x;
    out_t right_y;
    out_t right_z;
    out_t up_x;
    out_t up_y;
    out_t up_z;
    out_t look_x;
    out_t look_y;
    out_t look_z;
    out_t look_w;
  } res_t;

endpackage

`default_nettype wire

FILE: sv/lab_in_if.sv
// Input channel interface: position and target beat with valid and ready.
`default_nettype none

interface lab_in_if;
  import lab_pkg::*;

  logic              valid;
  logic              ready;
  logic signed [IN_W-1:0] position_x;
  logic signed [IN_W-1:0] position_y;
  logic signed [IN_W-1:0] position_z;
  logic signed [IN_W-1:0] position_w;
  logic signed [IN_W-1:0] target_x;
  logic signed [IN_W-1:0] target_y;
  logic signed [IN_W-1:0] target_z;
  logic signed [IN_W-1:0] target_w;

  modport source (
    output valid, position_x, position_y, position_z, position_w,
    output target_x, target_y, target_z, target_w,
    input  ready
  );

  modport sink (
    input  valid, position_x, position_y, position_z, position_w,
    input  target_x, target_y, target_z, target_w,
    output ready
  );

endinterface

`default_nettype wire

FILE: sv/lab_out_if.sv
// Result channel interface: camera basis beat with valid and ready.
`default_nettype none

interface lab_out_if;
  import lab_pkg::*;

  logic valid;
  logic ready;
  out_t right_x;
  out_t right_y;
  out_t right_z;
  out_t up_x;
  out_t up_y;
  out_t up_z;
  out_t look_x;
  out_t look_y;
  out_t look_z;
  out_t look_w;

  modport source (
    output valid, right_x, right_y, right_z, up_x, up_y, up_z,
    output look_x, look_y, look_z, look_w,
    input  ready
  );

  modport sink (
    input  valid, right_x, right_y, right_z, up_x, up_y, up_z,
    input  look_x, look_y, look_z, look_w,
    output ready
  );

endinterface

`default_nettype wire

FILE: sv/lab_norm.sv
// Pipelined four-lane vector normalizer with bit-serial square root and dividers.
`default_nettype none

module lab_norm (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  lab_pkg::vec4_t in_vec,
  input  lab_pkg::side_t in_side,
  output logic           out_valid,
  output lab_pkg::res4_t out_res,
  output lab_pkg::side_t out_side
);
  import lab_pkg::*;

  logic                     v1_r;
  logic [3:0][MAG33_W-1:0]  mag1_r;
  logic [3:0]               neg1_r;
  side_t                    side1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        neg1_r[i] <= in_vec[i][VEC_W-1];
        mag1_r[i] <= in_vec[i][VEC_W-1] ? MAG33_W'(-in_vec[i]) : MAG33_W'(in_vec[i]);
      end
      side1_r <= in_side;
    end
  end

  logic [MAG33_W-1:0]       mx01;
  logic [MAG33_W-1:0]       mx23;
  logic [MAG33_W-1:0]       mx_nxt;
  logic                     v2_r;
  logic [MAG33_W-1:0]       m2_r;
  logic [3:0][MAG33_W-1:0]  mag2_r;
  logic [3:0]               neg2_r;
  side_t                    side2_r;

  always_comb begin
    mx01   = (mag1_r[0] > mag1_r[1]) ? mag1_r[0] : mag1_r[1];
    mx23   = (mag1_r[2] > mag1_r[3]) ? mag1_r[2] : mag1_r[3];
    mx_nxt = (mx01 > mx23) ? mx01 : mx23;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_r    <= mx_nxt;
      mag2_r  <= mag1_r;
      neg2_r  <= neg1_r;
      side2_r <= side1_r;
    end
  end

  logic [P_W-1:0]           p_nxt;
  logic                     v3_r;
  logic [P_W-1:0]           p3_r;
  logic                     zero3_r;
  logic [3:0][MAG33_W-1:0]  mag3_r;
  logic [3:0]               neg3_r;
  side_t                    side3_r;

  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < MAG33_W; i++) begin
      if (m2_r[i]) begin
        p_nxt = P_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_r    <= p_nxt;
      zero3_r <= (m2_r == '0);
      mag3_r  <= mag2_r;
      neg3_r  <= neg2_r;
      side3_r <= side2_r;
    end
  end

  logic [3:0][MAG33_W-1:0]  sh;
  norm_pl_t                 pl4_nxt;
  logic                     v4_r;
  norm_pl_t                 pl4_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (p3_r >= P_W'(NORM_POS)) begin
        sh[i] = mag3_r[i] >> (p3_r - P_W'(NORM_POS));
      end else begin
        sh[i] = mag3_r[i] << (P_W'(NORM_POS) - p3_r);
      end
    end
    pl4_nxt.side = side3_r;
    pl4_nxt.zero = zero3_r;
    pl4_nxt.neg  = neg3_r;
    for (int i = 0; i < 4; i++) begin
      pl4_nxt.mag[i] = sh[i][MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl4_r <= pl4_nxt;
    end
  end

  logic                   v5_r;
  norm_pl_t               pl5_r;
  logic [3:0][SQ_W-1:0]   sq5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        sq5_r[i] <= SQ_W'(pl4_r.mag[i]) * SQ_W'(pl4_r.mag[i]);
      end
      pl5_r <= pl4_r;
    end
  end

  logic                sq_v_r    [0:SQ_STEPS];
  norm_pl_t            sq_pl_r   [0:SQ_STEPS];
  logic [SUM_W-1:0]    sq_s_r    [0:SQ_STEPS];
  logic [REM_W-2:0]    sq_rem_r  [0:SQ_STEPS];
  logic [ROOT_W-1:0]   sq_root_r [0:SQ_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (en) begin
      sq_v_r[0] <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_s_r[0]    <= SUM_W'(sq5_r[0]) + SUM_W'(sq5_r[1]) + SUM_W'(sq5_r[2])
                      + SUM_W'(sq5_r[3]);
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_pl_r[0]   <= pl5_r;
    end
  end

  for (genvar k = 1; k <= SQ_STEPS; k++) begin : g_sqrt
    logic [REM_W-1:0] rem2;
    logic [REM_W-1:0] trial;
    logic             take;

    always_comb begin
      rem2  = {sq_rem_r[k-1][REM_W-3:0], sq_s_r[k-1][SUM_W-1 -: 2]};
      trial = {sq_root_r[k-1], 2'b01};
      take  = (rem2 >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k] <= 1'b0;
      end else if (en) begin
        sq_v_r[k] <= sq_v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem_r[k]  <= take ? (REM_W-1)'(rem2 - trial) : rem2[REM_W-2:0];
        sq_root_r[k] <= {sq_root_r[k-1][ROOT_W-2:0], take};
        sq_s_r[k]    <= sq_s_r[k-1] << 2;
        sq_pl_r[k]   <= sq_pl_r[k-1];
      end
    end
  end

  logic                        dv_v_r    [0:DIV_STEPS];
  norm_pl_t                    dv_pl_r   [0:DIV_STEPS];
  logic [ROOT_W-1:0]           dv_root_r [0:DIV_STEPS];
  logic [3:0][ROOT_W-1:0]      dv_rem_r  [0:DIV_STEPS];
  logic [3:0][Q_W-1:0]         dv_low_r  [0:DIV_STEPS];
  logic [3:0][Q_W-1:0]         dv_q_r    [0:DIV_STEPS];
  logic [3:0][NUM_W-1:0]       num;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      num[i] = NUM_W'({sq_pl_r[SQ_STEPS].mag[i], {OUT_FRAC{1'b0}}})
               + NUM_W'(sq_root_r[SQ_STEPS] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= sq_v_r[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        dv_rem_r[0][i] <= ROOT_W'(num[i][NUM_W-1:Q_W]);
        dv_low_r[0][i] <= num[i][Q_W-1:0];
        dv_q_r[0][i]   <= '0;
      end
      dv_root_r[0] <= sq_root_r[SQ_STEPS];
      dv_pl_r[0]   <= sq_pl_r[SQ_STEPS];
    end
  end

  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
    logic [3:0][ROOT_W:0] rem2;
    logic [3:0]           take;

    always_comb begin
      for (int i = 0; i < 4; i++) begin
        rem2[i] = {dv_rem_r[j-1][i], dv_low_r[j-1][i][Q_W-1]};
        take[i] = (rem2[i] >= {1'b0, dv_root_r[j-1]});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j] <= 1'b0;
      end else if (en) begin
        dv_v_r[j] <= dv_v_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 4; i++) begin
          dv_rem_r[j][i] <= take[i] ? ROOT_W'(rem2[i] - {1'b0, dv_root_r[j-1]})
                                    : rem2[i][ROOT_W-1:0];
          dv_q_r[j][i]   <= {dv_q_r[j-1][i][Q_W-2:0], take[i]};
          dv_low_r[j][i] <= dv_low_r[j-1][i] << 1;
        end
        dv_root_r[j] <= dv_root_r[j-1];
        dv_pl_r[j]   <= dv_pl_r[j-1];
      end
    end
  end

  logic [3:0][Q_W-1:0] qc;
  logic                fin_v_r;
  res4_t               fin_res_r;
  side_t               fin_side_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qc[i] = (dv_q_r[DIV_STEPS][i] > Q_W'(ONE_OUT)) ? Q_W'(ONE_OUT)
                                                     : dv_q_r[DIV_STEPS][i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (en) begin
      fin_v_r <= dv_v_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        if (dv_pl_r[DIV_STEPS].zero) begin
          fin_res_r[i] <= '0;
        end else if (dv_pl_r[DIV_STEPS].neg[i]) begin
          fin_res_r[i] <= -OUT_W'(qc[i]);
        end else begin
          fin_res_r[i] <= OUT_W'(qc[i]);
        end
      end
      fin_side_r <= dv_pl_r[DIV_STEPS].side;
    end
  end

  assign out_valid = fin_v_r;
  assign out_res   = fin_res_r;
  assign out_side  = fin_side_r;

endmodule

`default_nettype wire

FILE: sv/lab_up.sv
// Right vector assembly and final up cross product with rounding.
`default_nettype none

module lab_up (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  lab_pkg::res4_t in_pair,
  input  lab_pkg::side_t in_side,
  output logic           out_valid,
  output lab_pkg::res_t  out_res
);
  import lab_pkg::*;

  function automatic out_t round_back(input logic signed [PROD_W:0] x);
    logic [PROD_W:0] u;
    logic [PROD_W:0] q;
    u = x[PROD_W] ? (PROD_W+1)'(-x) : (PROD_W+1)'(x);
    q = (u + (PROD_W+1)'(HALF_OUT)) >> OUT_FRAC;
    if (q > (PROD_W+1)'(ONE_OUT)) begin
      q = (PROD_W+1)'(ONE_OUT);
    end
    return x[PROD_W] ? -OUT_W'(q) : OUT_W'(q);
  endfunction

  out_t n0;
  out_t n1;
  out_t rx;
  out_t ry;
  out_t rz;

  always_comb begin
    n0 = $signed(in_pair[0]);
    n1 = $signed(in_pair[1]);
    case (in_side.mode)
      MODE_X: begin
        rx = '0;
        ry = n0;
        rz = n1;
      end
      MODE_Z: begin
        rx = n0;
        ry = n1;
        rz = '0;
      end
      default: begin
        rx = n0;
        ry = '0;
        rz = n1;
      end
    endcase
  end

  logic                     v1_r;
  logic signed [PROD_W-1:0] p_r [6];
  res_t                     r1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= in_side.ly * rz;
      p_r[1] <= in_side.lz * ry;
      p_r[2] <= in_side.lz * rx;
      p_r[3] <= in_side.lx * rz;
      p_r[4] <= in_side.lx * ry;
      p_r[5] <= in_side.ly * rx;
      r1_r.right_x <= rx;
      r1_r.right_y <= ry;
      r1_r.right_z <= rz;
      r1_r.up_x    <= '0;
      r1_r.up_y    <= '0;
      r1_r.up_z    <= '0;
      r1_r.look_x  <= in_side.lx;
      r1_r.look_y  <= in_side.ly;
      r1_r.look_z  <= in_side.lz;
      r1_r.look_w  <= in_side.lw;
    end
  end

  logic                     v2_r;
  res_t                     r2_r;
  res_t                     r2_nxt;

  always_comb begin
    r2_nxt      = r1_r;
    r2_nxt.up_x = round_back({p_r[0][PROD_W-1], p_r[0]} - {p_r[1][PROD_W-1], p_r[1]});
    r2_nxt.up_y = round_back({p_r[2][PROD_W-1], p_r[2]} - {p_r[3][PROD_W-1], p_r[3]});
    r2_nxt.up_z = round_back({p_r[4][PROD_W-1], p_r[4]} - {p_r[5][PROD_W-1], p_r[5]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2_r <= r2_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_res   = r2_r;

endmodule

`default_nettype wire

FILE: sv/lab_skid.sv
// Two-entry output buffer that decouples the pipeline from the result sink.
`default_nettype none

module lab_skid (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lab_pkg::res_t din,
  input  logic          out_ready,
  output logic          out_valid,
  output lab_pkg::res_t dout,
  output logic          space
);
  import lab_pkg::*;

  res_t       buf_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;
  assign dout      = buf_r[rp_r];
  assign space     = (cnt_r != 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= din;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("output buffer count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && cnt_r == 2'd2))
    else $error("beat pushed into a full output buffer");
  a_fill_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop && cnt_r == 2'd1) |=> !space)
    else $error("pipeline not stalled when output buffer filled");
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push && cnt_r == 2'd2) |=> (cnt_r == 2'd1 && space))
    else $error("output buffer did not drain by one beat");
`endif

endmodule

`default_nettype wire

FILE: sv/look_at_basis_builder_unit.sv
// Throughput: one beat per cycle while the output buffer has space; every stage,
// including the 31-stage square root and the 15-stage dividers of both
// normalizers, is fully pipelined.
// A two-entry output buffer keeps accepting while one result waits to be taken.
// Reset: synchronous active-low rst_n clears all valid bits and the buffer count.
`default_nettype none

module look_at_basis_builder_unit (
  input  logic      clk,
  input  logic      rst_n,
  lab_in_if.sink    in_ch,
  lab_out_if.source out_ch
);
  import lab_pkg::*;

  logic  en;
  logic  v0_r;
  vec4_t d_r;

  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0] <= VEC_W'(in_ch.target_x) - VEC_W'(in_ch.position_x);
      d_r[1] <= VEC_W'(in_ch.target_y) - VEC_W'(in_ch.position_y);
      d_r[2] <= VEC_W'(in_ch.target_z) - VEC_W'(in_ch.position_z);
      d_r[3] <= VEC_W'(in_ch.target_w) - VEC_W'(in_ch.position_w);
    end
  end

  logic  lk_valid;
  res4_t lk_res;
  side_t lk_side;

  lab_norm u_norm_look (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v0_r),
    .in_vec   (d_r),
    .in_side  ('0),
    .out_valid(lk_valid),
    .out_res  (lk_res),
    .out_side (lk_side)
  );

  out_t  lx;
  out_t  ly;
  out_t  lz;
  side_t sel_side;
  vec4_t pair_vec;

  always_comb begin
    lx = $signed(lk_res[0]);
    ly = $signed(lk_res[1]);
    lz = $signed(lk_res[2]);
    sel_side    = lk_side;
    sel_side.lx = lx;
    sel_side.ly = ly;
    sel_side.lz = lz;
    sel_side.lw = $signed(lk_res[3]);
    pair_vec    = '0;
    if (ly == '0) begin
      sel_side.mode = MODE_X;
      pair_vec[0]   = -VEC_W'(lz);
      pair_vec[1]   = VEC_W'(ly);
    end else if (lx == '0) begin
      sel_side.mode = MODE_Z;
      pair_vec[0]   = -VEC_W'(ly);
      pair_vec[1]   = VEC_W'(lx);
    end else begin
      sel_side.mode = MODE_Y;
      pair_vec[0]   = VEC_W'(lz);
      pair_vec[1]   = -VEC_W'(lx);
    end
  end

  logic  rt_valid;
  res4_t rt_res;
  side_t rt_side;

  lab_norm u_norm_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (lk_valid),
    .in_vec   (pair_vec),
    .in_side  (sel_side),
    .out_valid(rt_valid),
    .out_res  (rt_res),
    .out_side (rt_side)
  );

  logic up_valid;
  res_t up_res;

  lab_up u_up (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (rt_valid),
    .in_pair  (rt_res),
    .in_side  (rt_side),
    .out_valid(up_valid),
    .out_res  (up_res)
  );

  res_t ob_res;

  lab_skid u_skid (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (en && up_valid),
    .din      (up_res),
    .out_ready(out_ch.ready),
    .out_valid(out_ch.valid),
    .dout     (ob_res),
    .space    (en)
  );

  assign out_ch.right_x = ob_res.right_x;
  assign out_ch.right_y = ob_res.right_y;
  assign out_ch.right_z = ob_res.right_z;
  assign out_ch.up_x    = ob_res.up_x;
  assign out_ch.up_y    = ob_res.up_y;
  assign out_ch.up_z    = ob_res.up_z;
  assign out_ch.look_x  = ob_res.look_x;
  assign out_ch.look_y  = ob_res.look_y;
  assign out_ch.look_z  = ob_res.look_z;
  assign out_ch.look_w  = ob_res.look_w;

endmodule

`default_nettype wire
